// ----- hdl/lofsw_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lofsw_pkg
// Shared constants and transaction types of the letter order unit.
// ----------------------------------------------------------------------------
package lofsw_pkg;

    localparam int ALPHABET_DEF = 26;
    localparam int MAX_WORD_DEF = 64;
    localparam int RESULT_LIMIT = 26;
    localparam int LETTER_W     = 5;

    typedef struct packed {
        logic [LETTER_W-1:0] letter;
        logic                no_letter;
        logic                word_end;
        logic                list_end;
    } lofsw_in_t;

    typedef struct packed {
        logic [LETTER_W-1:0] order_letter;
        logic                empty_result;
        logic                failed;
        logic                too_long;
        logic                last;
    } lofsw_out_t;

endpackage

// ----- hdl/lofsw_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lofsw_ram
// Simple dual-port synchronous RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
module lofsw_ram #(
    parameter int DEPTH = 2,
    parameter int WIDTH = 1,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- hdl/letter_order_from_sorted_words_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// letter_order_from_sorted_words_unit
// Derives a letter order from a sorted word list and emits it letter by letter.
// ----------------------------------------------------------------------------
//  Channel   Signals                  Transaction
//  input     start, busy, item        accepted when start is high and busy low
//  result    strobe, result           one-cycle strobe per result, cannot be stalled
//
// A letter item first reads the previous word's letter at the same position,
// then compares it and writes the new letter back. When the letters differ
// for the first time in a word, a further step reads and updates the edge
// matrix row. An item that ends the list starts the sort: a scan over all
// ALPHABET letters, then per placed letter a queue read, a row read and a
// row load followed by a pass relaxing its successors, then a queue read
// and an output step per emitted result. Reset clears all control state at once;
// the edge rows carry valid bits so the matrix needs no clearing pass.
// ----------------------------------------------------------------------------
module letter_order_from_sorted_words_unit
    import lofsw_pkg::*;
#(
    parameter int ALPHABET = ALPHABET_DEF,
    parameter int MAX_WORD = MAX_WORD_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  lofsw_in_t  item,
    output logic       strobe,
    output lofsw_out_t result
);

    localparam int AIW  = $clog2(ALPHABET);
    localparam int CW   = $clog2(ALPHABET + 1);
    localparam int PW   = (MAX_WORD > 1) ? $clog2(MAX_WORD) : 1;
    localparam int POSW = $clog2(MAX_WORD + 1);
    localparam int LIM  = (ALPHABET < RESULT_LIMIT) ? ALPHABET : RESULT_LIMIT;
    localparam logic [POSW-1:0]   MAXW_L  = POSW'(MAX_WORD);
    localparam logic [CW-1:0]     ALPHA_L = CW'(ALPHABET);
    localparam logic [CW-1:0]     LAST_C  = CW'(ALPHABET - 1);
    localparam logic [CW-1:0]     LIM_L   = CW'(LIM);
    localparam logic [LETTER_W:0] ALPHA_W = (LETTER_W + 1)'(ALPHABET);

    typedef enum logic [3:0] {
        S_IDLE, S_TAKE, S_EDGE, S_SCAN, S_POP, S_ROW, S_LOAD, S_RELAX,
        S_DECIDE, S_EREAD, S_EOUT
    } state_t;

    state_t             state_reg;
    lofsw_in_t          item_reg;
    logic [POSW-1:0]    pos_reg;
    logic [POSW-1:0]    prev_len_reg;
    logic               diverged_reg;
    logic               have_prev_reg;
    logic               overflow_reg;
    logic [ALPHABET-1:0] present_reg;
    logic [ALPHABET-1:0] row_valid_reg;
    logic               rv_reg;
    logic [AIW-1:0]     indeg_reg [ALPHABET];
    logic [AIW-1:0]     t_reg;
    logic [CW-1:0]      c_reg;
    logic [CW-1:0]      count_reg;
    logic [CW-1:0]      head_reg;
    logic [CW-1:0]      tail_reg;
    logic               strobe_reg;
    lofsw_out_t         result_reg;

    // Memory ports.
    logic                pw_we;
    logic [AIW-1:0]      pw_rdata;
    logic                e_we;
    logic [ALPHABET-1:0] e_wdata;
    logic [AIW-1:0]      e_raddr;
    logic [ALPHABET-1:0] e_rdata;
    logic                q_we;
    logic [AIW-1:0]      q_waddr;
    logic [AIW-1:0]      q_wdata;
    logic [AIW-1:0]      q_raddr;
    logic [AIW-1:0]      q_rdata;

    logic                has_letter;
    logic [AIW-1:0]      let_idx;
    logic [AIW-1:0]      c_idx;
    logic                compare;
    logic                need_edge;
    logic [ALPHABET-1:0] row;
    logic [POSW-1:0]     pos_inc;
    logic [CW-1:0]       lim;

    assign has_letter = !item_reg.no_letter && ({1'b0, item_reg.letter} < ALPHA_W);
    assign let_idx    = item_reg.letter[AIW-1:0];
    assign c_idx      = c_reg[AIW-1:0];
    assign compare    = have_prev_reg && !diverged_reg && (pos_reg < prev_len_reg);
    assign need_edge  = has_letter && (pos_reg < MAXW_L) && compare && (pw_rdata != let_idx);
    assign row        = rv_reg ? e_rdata : '0;
    assign pos_inc    = pos_reg + POSW'(1);
    assign lim        = (tail_reg < LIM_L) ? tail_reg : LIM_L;

    // The previous word store is written with the current letter while the
    // same entry's old value is compared; the read was issued at acceptance.
    assign pw_we   = (state_reg == S_TAKE) && has_letter && (pos_reg < MAXW_L);

    // The edge row address is the earlier letter while a letter is taken,
    // and the letter being retired during the sort.
    assign e_raddr = (state_reg == S_TAKE) ? pw_rdata : t_reg;
    assign e_we    = (state_reg == S_EDGE) && !row[let_idx];
    always_comb
    begin
        e_wdata = row;
        e_wdata[let_idx] = 1'b1;
    end

    // The ready queue is pushed in the scan and relax phases.
    always_comb
    begin
        q_we = 1'b0;
        if (state_reg == S_SCAN)
        begin
            q_we = present_reg[c_idx] && (indeg_reg[c_idx] == '0);
        end
        else if (state_reg == S_RELAX)
        begin
            q_we = row[c_idx] && (indeg_reg[c_idx] == AIW'(1)) && (tail_reg < ALPHA_L);
        end
    end
    assign q_waddr = tail_reg[AIW-1:0];
    assign q_wdata = c_idx;
    assign q_raddr = (state_reg == S_EREAD) ? c_idx : head_reg[AIW-1:0];

    lofsw_ram #(.DEPTH(MAX_WORD), .WIDTH(AIW)) u_prev_word (
        .clk   (clk),
        .we    (pw_we),
        .waddr (pos_reg[PW-1:0]),
        .wdata (let_idx),
        .raddr (pos_reg[PW-1:0]),
        .rdata (pw_rdata)
    );

    lofsw_ram #(.DEPTH(ALPHABET), .WIDTH(ALPHABET)) u_edge (
        .clk   (clk),
        .we    (e_we),
        .waddr (t_reg),
        .wdata (e_wdata),
        .raddr (e_raddr),
        .rdata (e_rdata)
    );

    lofsw_ram #(.DEPTH(ALPHABET), .WIDTH(AIW)) u_queue (
        .clk   (clk),
        .we    (q_we),
        .waddr (q_waddr),
        .wdata (q_wdata),
        .raddr (q_raddr),
        .rdata (q_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pos_reg       <= '0;
            prev_len_reg  <= '0;
            diverged_reg  <= 1'b0;
            have_prev_reg <= 1'b0;
            overflow_reg  <= 1'b0;
            present_reg   <= '0;
            row_valid_reg <= '0;
            rv_reg        <= 1'b0;
            for (int i = 0; i < ALPHABET; i++)
            begin
                indeg_reg[i] <= '0;
            end
            c_reg         <= '0;
            count_reg     <= '0;
            head_reg      <= '0;
            tail_reg      <= '0;
            strobe_reg    <= 1'b0;
        end
        else
        begin
            strobe_reg <= 1'b0;
            rv_reg     <= row_valid_reg[e_raddr];
            unique case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        state_reg <= S_TAKE;
                    end
                end
                S_TAKE:
                begin
                    t_reg <= pw_rdata;
                    if (has_letter)
                    begin
                        present_reg[let_idx] <= 1'b1;
                        if (pos_reg >= MAXW_L)
                        begin
                            overflow_reg <= 1'b1;
                        end
                        else
                        begin
                            pos_reg <= pos_inc;
                            if (need_edge)
                            begin
                                diverged_reg <= 1'b1;
                            end
                        end
                    end
                    if (need_edge)
                    begin
                        state_reg <= S_EDGE;
                    end
                    else
                    begin
                        if (item_reg.word_end || item_reg.list_end)
                        begin
                            prev_len_reg  <= (has_letter && pos_reg < MAXW_L) ? pos_inc
                                                                              : pos_reg;
                            pos_reg       <= '0;
                            diverged_reg  <= 1'b0;
                            have_prev_reg <= 1'b1;
                        end
                        state_reg <= item_reg.list_end ? S_SCAN : S_IDLE;
                        c_reg     <= '0;
                    end
                end
                S_EDGE:
                begin
                    if (!row[let_idx])
                    begin
                        row_valid_reg[t_reg] <= 1'b1;
                        indeg_reg[let_idx]   <= indeg_reg[let_idx] + AIW'(1);
                    end
                    if (item_reg.word_end || item_reg.list_end)
                    begin
                        prev_len_reg  <= pos_reg;
                        pos_reg       <= '0;
                        diverged_reg  <= 1'b0;
                        have_prev_reg <= 1'b1;
                    end
                    state_reg <= item_reg.list_end ? S_SCAN : S_IDLE;
                    c_reg     <= '0;
                end
                S_SCAN:
                begin
                    if (present_reg[c_idx])
                    begin
                        count_reg <= count_reg + CW'(1);
                    end
                    if (q_we)
                    begin
                        tail_reg <= tail_reg + CW'(1);
                    end
                    c_reg <= c_reg + CW'(1);
                    if (c_reg == LAST_C)
                    begin
                        state_reg <= S_POP;
                    end
                end
                S_POP:
                begin
                    // The queue read of the head entry is issued here.
                    state_reg <= (head_reg < tail_reg) ? S_ROW : S_DECIDE;
                end
                S_ROW:
                begin
                    t_reg     <= q_rdata;
                    head_reg  <= head_reg + CW'(1);
                    state_reg <= S_LOAD;
                end
                S_LOAD:
                begin
                    c_reg     <= '0;
                    state_reg <= S_RELAX;
                end
                S_RELAX:
                begin
                    if (row[c_idx] && indeg_reg[c_idx] != '0)
                    begin
                        indeg_reg[c_idx] <= indeg_reg[c_idx] - AIW'(1);
                    end
                    if (q_we)
                    begin
                        tail_reg <= tail_reg + CW'(1);
                    end
                    c_reg <= c_reg + CW'(1);
                    if (c_reg == LAST_C)
                    begin
                        state_reg <= S_POP;
                    end
                end
                S_DECIDE:
                begin
                    c_reg <= '0;
                    if (tail_reg < count_reg || count_reg == '0)
                    begin
                        strobe_reg              <= 1'b1;
                        result_reg.order_letter <= '0;
                        result_reg.empty_result <= (count_reg == '0);
                        result_reg.failed       <= (tail_reg < count_reg);
                        result_reg.too_long     <= overflow_reg;
                        result_reg.last         <= 1'b1;
                        state_reg               <= S_IDLE;
                    end
                    else
                    begin
                        state_reg <= S_EREAD;
                    end
                end
                S_EREAD:
                begin
                    state_reg <= S_EOUT;
                end
                S_EOUT:
                begin
                    strobe_reg              <= 1'b1;
                    result_reg.order_letter <= LETTER_W'(q_rdata);
                    result_reg.empty_result <= 1'b0;
                    result_reg.failed       <= 1'b0;
                    result_reg.too_long     <= overflow_reg;
                    result_reg.last         <= (c_reg + CW'(1) == lim);
                    c_reg                   <= c_reg + CW'(1);
                    state_reg               <= (c_reg + CW'(1) == lim) ? S_IDLE : S_EREAD;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase

            // The whole list state is dropped when the last result leaves.
            if ((state_reg == S_DECIDE && (tail_reg < count_reg || count_reg == '0)) ||
                (state_reg == S_EOUT && c_reg + CW'(1) == lim))
            begin
                pos_reg       <= '0;
                prev_len_reg  <= '0;
                diverged_reg  <= 1'b0;
                have_prev_reg <= 1'b0;
                overflow_reg  <= 1'b0;
                present_reg   <= '0;
                row_valid_reg <= '0;
                for (int i = 0; i < ALPHABET; i++)
                begin
                    indeg_reg[i] <= '0;
                end
                count_reg <= '0;
                head_reg  <= '0;
                tail_reg  <= '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && start)
        begin
            item_reg <= item;
        end
    end

    assign busy   = (state_reg != S_IDLE);
    assign strobe = strobe_reg;
    assign result = result_reg;

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("accepted transaction did not make the unit busy");

    a_strobe_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> $past(busy))
        else $error("result strobe without a sort in progress");

    a_queue_order: assert property (@(posedge clk) disable iff (!rst_n)
        head_reg <= tail_reg && tail_reg <= ALPHA_L)
        else $error("ready queue pointers out of order");

endmodule
